FILE: rtl/cstok_pkg.sv
`timescale 1ns / 1ps
// Package for the C subset tokenizer: token kinds, result types and keyword tables.
// Depends on nothing; used by cstok_lex and c_subset_tokenizer.
package cstok_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int LEN_BITS        = 16;
  localparam int START_BITS      = 16;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  localparam logic [3:0] KIND_INT     = 4'd0;
  localparam logic [3:0] KIND_RETURN  = 4'd1;
  localparam logic [3:0] KIND_IDENT   = 4'd2;
  localparam logic [3:0] KIND_NUMBER  = 4'd3;
  localparam logic [3:0] KIND_LPAREN  = 4'd4;
  localparam logic [3:0] KIND_RPAREN  = 4'd5;
  localparam logic [3:0] KIND_LBRACE  = 4'd6;
  localparam logic [3:0] KIND_RBRACE  = 4'd7;
  localparam logic [3:0] KIND_SEMI    = 4'd8;
  localparam logic [3:0] KIND_ASSIGN  = 4'd9;
  localparam logic [3:0] KIND_PLUS    = 4'd10;
  localparam logic [3:0] KIND_EOF     = 4'd11;
  localparam logic [3:0] KIND_UNKNOWN = 4'd12;

  typedef struct packed {
    logic [3:0]            kind;
    logic [START_BITS-1:0] start;
    logic [LEN_BITS-1:0]   length;
    logic                  last;
  } token_t;

  // Up to two tokens per byte: a flushed pending token, then the byte's own token.
  typedef struct packed {
    token_t     first;
    token_t     second;
    logic [1:0] count;
  } lex_res_t;

  function automatic logic [7:0] kw_int_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = "i";
      2'd1:    ch = "n";
      default: ch = "t";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_return_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "r";
      3'd1:    ch = "e";
      3'd2:    ch = "t";
      3'd3:    ch = "u";
      3'd4:    ch = "r";
      default: ch = "n";
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/cstok_lex.sv
`timescale 1ns / 1ps
// Lexer core: scan state, offset counter and the per-byte token decode.
// Depends on cstok_pkg.
module cstok_lex
  import cstok_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] char_in,
  output lex_res_t   res
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  logic [1:0]             mode, mode_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [OFFSET_BITS-1:0] pend_start, pend_start_next;
  logic [LEN_BITS-1:0]    pend_len, pend_len_next;
  logic                   int_ok, int_ok_next;
  logic                   ret_ok, ret_ok_next;

  logic                is_letter, is_decimal, is_space, is_nul;
  logic                in_ident, in_number;
  logic [LEN_BITS-1:0] len_inc;
  logic                flush_v, own_v;
  token_t              flush_tok, own_tok;
  logic [3:0]          flush_kind, punct_kind;
  logic [START_BITS-1:0] here;

  always_comb begin
    is_letter  = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z") ||
                 (char_in == "_");
    is_decimal = (char_in >= "0" && char_in <= "9");
    is_space   = (char_in == " ") || (char_in >= 8'd9 && char_in <= 8'd13);
    is_nul     = (char_in == 8'd0);
    // The unused mode code behaves as idle.
    in_ident  = (mode == MODE_IDENT);
    in_number = (mode == MODE_NUMBER);
    len_inc   = (pend_len == LEN_MAX) ? pend_len : pend_len + 1'b1;
    here      = START_BITS'(offset);

    if (in_ident && int_ok && pend_len == LEN_BITS'(3)) begin
      flush_kind = KIND_INT;
    end else if (in_ident && ret_ok && pend_len == LEN_BITS'(6)) begin
      flush_kind = KIND_RETURN;
    end else if (in_ident) begin
      flush_kind = KIND_IDENT;
    end else begin
      flush_kind = KIND_NUMBER;
    end

    unique case (char_in)
      "(":     punct_kind = KIND_LPAREN;
      ")":     punct_kind = KIND_RPAREN;
      "{":     punct_kind = KIND_LBRACE;
      "}":     punct_kind = KIND_RBRACE;
      ";":     punct_kind = KIND_SEMI;
      "=":     punct_kind = KIND_ASSIGN;
      "+":     punct_kind = KIND_PLUS;
      default: punct_kind = KIND_UNKNOWN;
    endcase

    flush_tok.kind   = flush_kind;
    flush_tok.start  = START_BITS'(pend_start);
    flush_tok.length = pend_len;
    flush_tok.last   = 1'b0;

    own_tok.kind   = is_nul ? KIND_EOF : punct_kind;
    own_tok.start  = here;
    own_tok.length = is_nul ? '0 : LEN_BITS'(1);
    own_tok.last   = 1'b1;

    mode_next       = mode;
    offset_next     = offset + 1'b1;
    pend_start_next = pend_start;
    pend_len_next   = pend_len;
    int_ok_next     = int_ok;
    ret_ok_next     = ret_ok;
    flush_v         = 1'b0;
    own_v           = 1'b0;

    if (is_nul) begin
      flush_v     = in_ident || in_number;
      own_v       = 1'b1;
      mode_next   = MODE_IDLE;
      offset_next = '0;
    end else if (in_ident && (is_letter || is_decimal)) begin
      int_ok_next   = int_ok && (pend_len < LEN_BITS'(3)) &&
                      (char_in == kw_int_char(pend_len[1:0]));
      ret_ok_next   = ret_ok && (pend_len < LEN_BITS'(6)) &&
                      (char_in == kw_return_char(pend_len[2:0]));
      pend_len_next = len_inc;
    end else if (in_number && is_decimal) begin
      pend_len_next = len_inc;
    end else begin
      flush_v   = in_ident || in_number;
      mode_next = MODE_IDLE;
      if (is_letter || is_decimal) begin
        mode_next       = is_letter ? MODE_IDENT : MODE_NUMBER;
        pend_start_next = offset;
        pend_len_next   = LEN_BITS'(1);
        int_ok_next     = (char_in == "i");
        ret_ok_next     = (char_in == "r");
      end else begin
        own_v = !is_space;
      end
    end

    // A lone flush is the final result of its byte.
    res.first      = flush_v ? flush_tok : own_tok;
    res.first.last = !(flush_v && own_v);
    res.second     = own_tok;
    res.count      = {1'b0, flush_v} + {1'b0, own_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      offset     <= '0;
      pend_start <= '0;
      pend_len   <= '0;
      int_ok     <= 1'b0;
      ret_ok     <= 1'b0;
    end else if (go) begin
      mode       <= mode_next;
      offset     <= offset_next;
      pend_start <= pend_start_next;
      pend_len   <= pend_len_next;
      int_ok     <= int_ok_next;
      ret_ok     <= ret_ok_next;
    end
  end

endmodule

FILE: rtl/c_subset_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the C subset tokenizer: input register, lexer core and result queue.
// Depends on cstok_pkg and cstok_lex.

// The tokenizer takes one source byte per beat on char_in and delivers tokens, each with
// its kind, its start offset and its length, on the output channel. Whitespace produces
// nothing; a byte that completes an identifier or number first releases that token and
// then its own, so one byte gives zero, one or two tokens, and last_of_run marks the final
// token of each byte. A zero byte closes the source with an EOF token and restarts the
// offset at zero. An accepted byte sits in an input register until it advances, is decoded in
// a single combinational pass against the scan state, and its tokens land in a three-entry
// result queue, which registers them; the earliest token is offered from the queue once it
// is written there. The block takes one byte per cycle for as long as the output drains
// one token per cycle; the output channel moves at most one token a cycle, so each byte
// that yields two tokens stalls the input, and any output stall propagates back once the
// queue holds two tokens. Reset clears the scan state and the queue.
module c_subset_tokenizer
  import cstok_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            char_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            token_kind,
  output logic [START_BITS-1:0] token_start,
  output logic [LEN_BITS-1:0]   token_length,
  output logic                  last_of_run
);

  localparam int QDEPTH = 3;

  // Input register: holds one byte until the queue has room for two tokens.
  logic       s_valid;
  logic [7:0] s_char;
  logic       accept, advance;

  lex_res_t   res;

  // Result queue: pointers wrap modulo three.
  token_t     q [QDEPTH];
  logic [1:0] rd_ptr, wr_ptr, count;
  logic [1:0] push_n;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(QDEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  // A byte advances only when the queue can take the worst case of two tokens.
  assign advance  = s_valid && (count <= 2'(QDEPTH - 2));
  assign in_stall = s_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_char <= char_in;
    end
  end

  cstok_lex #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_lex (
    .clk     (clk),
    .rst     (rst),
    .go      (advance),
    .char_in (s_char),
    .res     (res)
  );

  assign push_n    = advance ? res.count : 2'd0;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push_n == 2'd2) begin
        wr_ptr <= ptr_inc(ptr_inc(wr_ptr));
      end else if (push_n == 2'd1) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      count <= count + push_n - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wr_ptr] <= res.first;
    end
    if (push_n == 2'd2) begin
      q[ptr_inc(wr_ptr)] <= res.second;
    end
  end

  assign token_kind   = q[rd_ptr].kind;
  assign token_start  = q[rd_ptr].start;
  assign token_length = q[rd_ptr].length;
  assign last_of_run  = q[rd_ptr].last;

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    !(count == 2'(QDEPTH) && push_n != 2'd0))
    else $error("result queue written while full");

  a_eof_last : assert property (@(posedge clk) disable iff (rst)
    (advance && s_char == 8'd0) |->
      (res.count != 2'd0) &&
      ((res.count == 2'd1 && res.first.kind == KIND_EOF) ||
       (res.count == 2'd2 && res.second.kind == KIND_EOF)))
    else $error("zero byte did not end with an EOF token");

  a_pair_is_flush : assert property (@(posedge clk) disable iff (rst)
    (advance && res.count == 2'd2) |->
      !res.first.last &&
      (res.first.kind == KIND_INT || res.first.kind == KIND_RETURN ||
       res.first.kind == KIND_IDENT || res.first.kind == KIND_NUMBER))
    else $error("first of a token pair is not a flushed identifier or number");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> (count == 2'd0 && !s_valid))
    else $error("queue or input register not empty after reset");
`endif

endmodule

FILE: test/c_subset_tokenizer_tb.sv
`timescale 1ns / 1ps
// Testbench for c_subset_tokenizer: feeds source bytes, predicts the token stream and
// checks every output beat field by field. Depends on cstok_pkg and the tokenizer RTL.
module c_subset_tokenizer_tb
  import cstok_pkg::*;
;

  // Scan state of the predictor; value 3 is never entered.
  typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER} scan_e;

  // Tracks the lexer state on the input side and keeps the tokens still owed by the block.
  class token_scoreboard;
    token_t      due_tokens[$];
    token_t      byte_tokens[$];
    int          errors;
    scan_e       mode;
    logic [15:0] offset;
    logic [15:0] word_start;
    logic [15:0] word_len;
    logic        maybe_int;
    logic        maybe_return;
    string       kw_int    = "int";
    string       kw_return = "return";

    function new();
      errors       = 0;
      mode         = SCAN_IDLE;
      offset       = '0;
      word_start   = '0;
      word_len     = '0;
      maybe_int    = 1'b0;
      maybe_return = 1'b0;
    endfunction

    function bit is_ident_head(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_decimal(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void emit(logic [3:0] kind, logic [15:0] start, logic [15:0] len);
      token_t t;
      t.kind   = kind;
      t.start  = start;
      t.length = len;
      t.last   = 1'b0;
      byte_tokens.push_back(t);
    endfunction

    // Releases a pending identifier or number, deciding on keywords by its prefix flags.
    function void close_word();
      if (mode == SCAN_IDENT) begin
        if (maybe_int && word_len == 16'd3) emit(KIND_INT, word_start, word_len);
        else if (maybe_return && word_len == 16'd6) emit(KIND_RETURN, word_start, word_len);
        else emit(KIND_IDENT, word_start, word_len);
      end else if (mode == SCAN_NUMBER) begin
        emit(KIND_NUMBER, word_start, word_len);
      end
      mode = SCAN_IDLE;
    endfunction

    function void open_word(scan_e m, logic [7:0] c);
      mode         = m;
      word_start   = offset;
      word_len     = 16'd1;
      maybe_int    = (m == SCAN_IDENT) && c == "i";
      maybe_return = (m == SCAN_IDENT) && c == "r";
    endfunction

    // Called once per accepted input beat.
    function void note_byte(logic [7:0] c);
      byte_tokens = {};
      if (c == 8'd0) begin
        close_word();
        emit(KIND_EOF, offset, 16'd0);
        offset = '0;
      end else begin
        if (mode == SCAN_IDENT && (is_ident_head(c) || is_decimal(c))) begin
          maybe_int    = maybe_int && word_len < 3 && c == kw_int[word_len];
          maybe_return = maybe_return && word_len < 6 && c == kw_return[word_len];
          if (word_len != LEN_MAX) word_len++;
        end else if (mode == SCAN_NUMBER && is_decimal(c)) begin
          if (word_len != LEN_MAX) word_len++;
        end else begin
          close_word();
          if (is_ident_head(c)) begin
            open_word(SCAN_IDENT, c);
          end else if (is_decimal(c)) begin
            open_word(SCAN_NUMBER, c);
          end else if (!is_space(c)) begin
            case (c)
              "(":     emit(KIND_LPAREN, offset, 16'd1);
              ")":     emit(KIND_RPAREN, offset, 16'd1);
              "{":     emit(KIND_LBRACE, offset, 16'd1);
              "}":     emit(KIND_RBRACE, offset, 16'd1);
              ";":     emit(KIND_SEMI, offset, 16'd1);
              "=":     emit(KIND_ASSIGN, offset, 16'd1);
              "+":     emit(KIND_PLUS, offset, 16'd1);
              default: emit(KIND_UNKNOWN, offset, 16'd1);
            endcase
          end
        end
        offset++;
      end
      if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
      foreach (byte_tokens[i]) due_tokens.push_back(byte_tokens[i]);
    endfunction

    // Called once per accepted output beat.
    function void check_token(token_t got);
      token_t want;
      if (due_tokens.size() == 0) begin
        $display("%0t: token kind %0d start %0d length %0d arrived with none expected",
                 $time, got.kind, got.start, got.length);
        errors++;
        return;
      end
      want = due_tokens.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: token_kind expected %0d, got %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.start != want.start) begin
        $display("%0t: token_start expected %0d, got %0d", $time, want.start, got.start);
        errors++;
      end
      if (got.length != want.length) begin
        $display("%0t: token_length expected %0d, got %0d", $time, want.length, got.length);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last_of_run expected %0d, got %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic [7:0]            char_in   = 8'd0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [3:0]            token_kind;
  logic [START_BITS-1:0] token_start;
  logic [LEN_BITS-1:0]   token_length;
  logic                  last_of_run;

  token_scoreboard sb;
  int              idle_pct   = 0;
  int              stall_pct  = 0;
  int              bytes_sent = 0;

  // Letters and underscore occupy indexes 0 to 52, the digits 53 to 62.
  string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string punct = "(){};=+";
  // Keywords together with near misses: prefixes, extensions and altered spellings of them.
  string words[12] = '{"int", "return", "in", "intx", "retur", "returns", "Int", "i", "r",
                       "int0", "_int", "ret"};

  c_subset_tokenizer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_in      (char_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  always #5 clk = ~clk;

  // Output side: every beat taken is checked against the oldest prediction, and the stall
  // for the coming cycle is drawn afresh. Values read straight after the edge are the ones
  // the block saw at that edge, since everything it drives changes in the update region.
  always @(posedge clk) begin
    token_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.kind   = token_kind;
      seen.start  = token_start;
      seen.length = token_length;
      seen.last   = last_of_run;
      sb.check_token(seen);
    end
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Offers one byte, with random idle cycles first, and returns at the edge that takes it.
  // valid is only lowered during an idle gap, so it is never lowered and raised in one step.
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Mostly well-formed source: keywords and near misses, identifiers, numbers, punctuation
  // and whitespace, with a sprinkling of arbitrary bytes and end-of-source markers. Lexemes
  // often abut, so that one byte both ends a pending token and starts its own.
  task automatic send_random_lexeme();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      send_text(words[$urandom_range(11)]);
    end else if (pick < 35) begin
      send_byte(alnum[$urandom_range(52)]);
      repeat ($urandom_range(5)) send_byte(alnum[$urandom_range(62)]);
    end else if (pick < 50) begin
      repeat (1 + $urandom_range(4)) send_byte(alnum[53 + $urandom_range(9)]);
    end else if (pick < 65) begin
      send_byte(punct[$urandom_range(6)]);
    end else if (pick < 85) begin
      send_byte(($urandom_range(6) == 6) ? 8'd32 : 8'(9 + $urandom_range(4)));
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(8'd0);
    end
  endtask

  initial begin
    int idle_set[4]  = '{0, 80, 0, 19};
    int stall_set[4] = '{0, 0, 80, 19};
    int wait_cycles;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed source: both keywords, a keyword ending on punctuation, every single-byte
    // token, a letter straight after a number, high bytes, and an end of source that
    // first has to release a pending identifier. A bare zero byte follows.
    send_text("int\treturn(a1){_=12ab+;}");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h0B);
    send_byte("q");
    send_byte(8'd0);
    send_byte(8'd0);

    // Random source under each idling pattern in turn.
    foreach (idle_set[p]) begin
      idle_pct   = idle_set[p];
      stall_pct  = stall_set[p];
      bytes_sent = 0;
      while (bytes_sent < 125) send_random_lexeme();
    end
    in_valid <= 1'b0;

    // Let the result queue drain, then allow a few more cycles for anything unexpected.
    wait_cycles = 0;
    while (sb.due_tokens.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (sb.due_tokens.size() != 0) begin
      $display("%0t: %0d expected tokens never arrived", $time, sb.due_tokens.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
